### hdl/satl_pkg.sv
// Shared widths, constants and register indexes for the cache tag/LRU block.
package satl_pkg;

  localparam int ADDR_W     = 32;
  localparam int RANK_W     = 3;
  localparam int COUNT_W    = 32;
  localparam int SET_OUT_W  = 8;
  localparam int WAY_OUT_W  = 3;

  localparam int OB_W       = 5;
  localparam int SB_W       = 4;
  localparam int WAYS_CFG_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam int DEF_MAX_WAYS = 8;
  localparam int DEF_MAX_SETS = 256;

  localparam logic [OB_W-1:0]       OFFSET_LIMIT = 5'd16;
  localparam logic [RANK_W-1:0]     RANK_MAX     = 3'd7;
  localparam logic [RANK_W:0]       RANK_NONE    = {1'b1, {RANK_W{1'b0}}};

  localparam logic [OB_W-1:0]       OB_RESET   = 5'd4;
  localparam logic [SB_W-1:0]       SB_RESET   = 4'd3;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_SET_BITS    = 2'd1,
    REG_WAYS_IN_USE = 2'd2
  } cfg_reg_t;

endpackage

### hdl/satl_if.sv
// Lookup request and result channel interfaces.
interface satl_req_if;
  logic                        valid;
  logic                        ready;
  logic [satl_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface satl_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [satl_pkg::SET_OUT_W-1:0] set_index;
  logic [satl_pkg::WAY_OUT_W-1:0] way;
  logic                           evicted;
  logic [satl_pkg::COUNT_W-1:0]   hit_count;
  logic [satl_pkg::COUNT_W-1:0]   miss_count;

  modport source (output valid, output hit, output set_index, output way, output evicted,
                  output hit_count, output miss_count, input ready);
  modport sink   (input valid, input hit, input set_index, input way, input evicted,
                  input hit_count, input miss_count, output ready);
endinterface

### hdl/satl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/satl_lookup.sv
// One-pass tag compare, victim choice and LRU rank update for one set.
module satl_lookup #(
  parameter int MAX_WAYS = satl_pkg::DEF_MAX_WAYS,
  parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int WAYS_W   = $clog2(MAX_WAYS + 1)
) (
  input  logic [MAX_WAYS-1:0]                         vld,
  input  logic [MAX_WAYS-1:0][satl_pkg::ADDR_W-1:0]   tags,
  input  logic [MAX_WAYS-1:0][satl_pkg::RANK_W-1:0]   ranks,
  input  logic [satl_pkg::ADDR_W-1:0]                 tag,
  input  logic [WAYS_W-1:0]                           ways,
  output logic                                        hit,
  output logic                                        evicted,
  output logic [WAY_W-1:0]                            way,
  output logic [MAX_WAYS-1:0]                         nxt_vld,
  output logic [MAX_WAYS-1:0][satl_pkg::ADDR_W-1:0]   nxt_tags,
  output logic [MAX_WAYS-1:0][satl_pkg::RANK_W-1:0]   nxt_ranks
);
  localparam int RW = satl_pkg::RANK_W;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [WAY_W-1:0]    hway;
  logic [WAY_W-1:0]    fway;
  logic [WAY_W-1:0]    vway;
  logic                has_free;
  logic [RW-1:0]       oldest;
  logic [RW:0]         old_rank;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = WAYS_W'(w) < ways;
      match[w]  = in_use[w] && vld[w] && (tags[w] == tag);
    end
  end

  // descending scans leave the lowest-numbered way selected
  always_comb begin
    hit      = 1'b0;
    hway     = '0;
    has_free = 1'b0;
    fway     = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit  = 1'b1;
        hway = WAY_W'(w);
      end
      if (in_use[w] && !vld[w]) begin
        has_free = 1'b1;
        fway     = WAY_W'(w);
      end
    end
  end

  // LRU victim: lowest way with the largest rank
  always_comb begin
    oldest = '0;
    vway   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && ranks[w] > oldest) begin
        oldest = ranks[w];
        vway   = WAY_W'(w);
      end
    end
  end

  assign evicted  = !hit && !has_free;
  assign way      = hit ? hway : (has_free ? fway : vway);
  // a line that was invalid counts as older than every valid line
  assign old_rank = (hit || evicted) ? {1'b0, ranks[way]} : satl_pkg::RANK_NONE;

  always_comb begin
    nxt_vld   = vld;
    nxt_tags  = tags;
    nxt_ranks = ranks;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (in_use[v] && vld[v] && (WAY_W'(v) != way) &&
          ({1'b0, ranks[v]} < old_rank) && (ranks[v] != satl_pkg::RANK_MAX)) begin
        nxt_ranks[v] = ranks[v] + 1'b1;
      end
    end
    nxt_ranks[way] = '0;
    nxt_vld[way]   = 1'b1;
    nxt_tags[way]  = tag;
  end
endmodule

### hdl/set_associative_cache_tag_lru_core.sv
// The accepted address is registered in stage 1; the result word is then registered
//   in the result register that drives rsp.
// Throughput: one word per cycle unless rsp stalls; the set row is read from the
//   tag RAM in the accept cycle and written back from the update stage, with a
//   bypass for back-to-back accesses to the same set.
// Reset: config returns to offset 4, set bits 3, 2 ways; every set reads as
//   empty at once through per-set init flags; hit and miss counts clear.
module set_associative_cache_tag_lru_core #(
  parameter int MAX_WAYS = satl_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS = satl_pkg::DEF_MAX_SETS
) (
  input  logic                            clk,
  input  logic                            rst,
  satl_req_if.sink                        req,
  satl_rsp_if.source                      rsp,
  input  logic                            cfg_wr_en,
  input  logic [satl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [satl_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW      = satl_pkg::ADDR_W;
  localparam int RW      = satl_pkg::RANK_W;
  localparam int OBW     = satl_pkg::OB_W;
  localparam int SBW     = satl_pkg::SB_W;
  localparam int WCW     = satl_pkg::WAYS_CFG_W;
  localparam int SO_W    = satl_pkg::SET_OUT_W;
  localparam int WO_W    = satl_pkg::WAY_OUT_W;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_W  = $clog2(MAX_WAYS + 1);
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int ROW_W   = MAX_WAYS * (1 + AW + RW);

  // configuration
  logic [OBW-1:0]    offset_bits;
  logic [SBW-1:0]    set_bits;
  logic [WCW-1:0]    ways_in_use;
  logic [OBW-1:0]    ob_eff;
  logic [SBW-1:0]    sb_eff;
  logic [WAYS_W-1:0] ways_eff;
  logic [SET_W:0]    set_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= satl_pkg::OB_RESET;
      set_bits    <= satl_pkg::SB_RESET;
      ways_in_use <= satl_pkg::WAYS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        satl_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        satl_pkg::REG_SET_BITS:    set_bits    <= cfg_data[SBW-1:0];
        satl_pkg::REG_WAYS_IN_USE: ways_in_use <= cfg_data[WCW-1:0];
        default: ;
      endcase
    end
  end

  assign ob_eff = (offset_bits > satl_pkg::OFFSET_LIMIT) ? satl_pkg::OFFSET_LIMIT
                                                          : offset_bits;
  assign sb_eff = (set_bits > SBW'(SET_LIM)) ? SBW'(SET_LIM) : set_bits;

  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = WAYS_W'(1);
    end else if ((WAYS_W + WCW)'(ways_in_use) > (WAYS_W + WCW)'(MAX_WAYS)) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_W'(ways_in_use);
    end
  end

  assign set_mask = ((SET_W + 1)'(1) << sb_eff) - 1'b1;

  // handshake and stage control
  logic             s1_valid;
  logic             s1_fire;
  logic             accept;
  logic             rsp_valid;
  logic [SET_W-1:0] rd_set;

  assign s1_fire   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rd_set    = SET_W'(req.address >> ob_eff) & set_mask[SET_W-1:0];

  // stage 1 registers
  logic [AW-1:0]       s1_addr;
  logic [SET_W-1:0]    s1_set;
  logic                s1_fwd;
  logic                s1_init;
  logic [ROW_W-1:0]    fwd_row;
  logic [MAX_SETS-1:0] row_init;

  logic [ROW_W-1:0]                 ram_rdata;
  logic [ROW_W-1:0]                 cur_row;
  logic [ROW_W-1:0]                 new_row;
  logic [MAX_WAYS-1:0]              cur_vld;
  logic [MAX_WAYS-1:0][AW-1:0]      cur_tags;
  logic [MAX_WAYS-1:0][RW-1:0]      cur_ranks;
  logic [MAX_WAYS-1:0]              nxt_vld;
  logic [MAX_WAYS-1:0][AW-1:0]      nxt_tags;
  logic [MAX_WAYS-1:0][RW-1:0]      nxt_ranks;
  logic [AW-1:0]                    s1_tag;
  logic [OBW:0]                     shift;
  logic                             lk_hit;
  logic                             lk_evicted;
  logic [WAY_W-1:0]                 lk_way;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      row_init <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        row_init[s1_set] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= req.address;
      s1_set  <= rd_set;
      s1_init <= row_init[rd_set];
      // the RAM returns the old row when the update stage writes it this cycle
      s1_fwd  <= s1_fire && (s1_set == rd_set);
      fwd_row <= new_row;
    end
  end

  satl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_set),
    .wdata (new_row),
    .re    (accept),
    .raddr (rd_set),
    .rdata (ram_rdata)
  );

  assign cur_row = s1_fwd ? fwd_row : (s1_init ? ram_rdata : '0);
  assign {cur_vld, cur_tags, cur_ranks} = cur_row;
  assign new_row = {nxt_vld, nxt_tags, nxt_ranks};

  assign shift  = (OBW + 1)'(ob_eff) + (OBW + 1)'(sb_eff);
  assign s1_tag = s1_addr >> shift;

  satl_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .WAY_W    (WAY_W),
    .WAYS_W   (WAYS_W)
  ) u_lookup (
    .vld       (cur_vld),
    .tags      (cur_tags),
    .ranks     (cur_ranks),
    .tag       (s1_tag),
    .ways      (ways_eff),
    .hit       (lk_hit),
    .evicted   (lk_evicted),
    .way       (lk_way),
    .nxt_vld   (nxt_vld),
    .nxt_tags  (nxt_tags),
    .nxt_ranks (nxt_ranks)
  );

  // result stage; counters only move when the result register is free
  logic [satl_pkg::COUNT_W-1:0] hits_total;
  logic [satl_pkg::COUNT_W-1:0] misses_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid    <= 1'b0;
      hits_total   <= '0;
      misses_total <= '0;
    end else begin
      if (s1_fire) begin
        rsp_valid <= 1'b1;
        if (lk_hit) begin
          if (hits_total != '1) begin
            hits_total <= hits_total + 1'b1;
          end
        end else if (misses_total != '1) begin
          misses_total <= misses_total + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      rsp.hit       <= lk_hit;
      rsp.set_index <= SO_W'(s1_set);
      rsp.way       <= WO_W'(lk_way);
      rsp.evicted   <= lk_evicted;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit_count  = hits_total;
  assign rsp.miss_count = misses_total;
endmodule

### tb/sv/satl_tb_pkg.sv
`timescale 1ns / 1ps
// Cache tag/LRU scoreboard: predicts each lookup's result word and checks returned words.
package satl_tb_pkg;
  import satl_pkg::*;

  localparam int SETS  = DEF_MAX_SETS;
  localparam int WAYS  = DEF_MAX_WAYS;
  localparam int LINES = SETS * WAYS;

  typedef struct packed {
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [WAY_OUT_W-1:0] way;
    logic                 evicted;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
  } lookup_result_t;

  class lru_tag_scoreboard;
    logic [OB_W-1:0]       offset_bits;
    logic [SB_W-1:0]       set_bits;
    logic [WAYS_CFG_W-1:0] ways_in_use;

    bit                    line_valid [LINES];
    logic [ADDR_W-1:0]     line_tag   [LINES];
    logic [RANK_W-1:0]     line_rank  [LINES];
    logic [COUNT_W-1:0]    hits_total;
    logic [COUNT_W-1:0]    misses_total;

    lookup_result_t        expected_lookups[$];
    int                    accesses;
    int                    mismatches;
    int                    hits_seen;
    int                    evictions_seen;

    function new();
      offset_bits  = OB_RESET;
      set_bits     = SB_RESET;
      ways_in_use  = WAYS_RESET;
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_rank[i]  = '0;
      end
      hits_total     = '0;
      misses_total   = '0;
      accesses       = 0;
      mismatches     = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    endfunction

    function int eff_offset();
      return (offset_bits > OFFSET_LIMIT) ? int'(OFFSET_LIMIT) : int'(offset_bits);
    endfunction

    function int eff_set_bits();
      int s;
      s = int'(set_bits);
      while (s > 0 && (1 << s) > SETS) s--;
      return s;
    endfunction

    function int eff_ways();
      if (ways_in_use == 0) return 1;
      if (ways_in_use > WAYS) return WAYS;
      return int'(ways_in_use);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_OFFSET_BITS: offset_bits = data;
        REG_SET_BITS:    set_bits    = data[SB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use = data[WAYS_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Way w becomes MRU; valid ways younger than its old rank age by one.
    // A way that was invalid counts as older than all.
    function void make_recent(int base, int w, int nways, bit was_valid);
      int old_rank;
      old_rank = was_valid ? int'(line_rank[base + w]) : int'(RANK_NONE);
      for (int v = 0; v < nways; v++) begin
        if (v == w || !line_valid[base + v]) continue;
        if (int'(line_rank[base + v]) < old_rank && line_rank[base + v] < RANK_MAX)
          line_rank[base + v] = line_rank[base + v] + 1'b1;
      end
      line_rank[base + w] = '0;
    endfunction

    function void note_access(logic [ADDR_W-1:0] addr);
      lookup_result_t    r;
      int                ob;
      int                sbits;
      int                nways;
      int                base;
      int                victim;
      int                oldest;
      logic [ADDR_W-1:0] tag;
      logic [ADDR_W-1:0] set_sel;
      ob      = eff_offset();
      sbits   = eff_set_bits();
      nways   = eff_ways();
      tag     = addr >> (ob + sbits);
      set_sel = (addr >> ob) & ((32'd1 << sbits) - 32'd1);
      base    = int'(set_sel) * WAYS;
      r       = '0;
      r.set_index = set_sel[SET_OUT_W-1:0];
      for (int w = 0; w < nways; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag) begin
          r.hit = 1'b1;
          r.way = WAY_OUT_W'(w);
          break;
        end
      end
      if (r.hit) begin
        if (hits_total != '1) hits_total++;
        make_recent(base, int'(r.way), nways, 1'b1);
      end else begin
        if (misses_total != '1) misses_total++;
        victim = -1;
        for (int w = 0; w < nways; w++) begin
          if (!line_valid[base + w]) begin
            victim = w;
            break;
          end
        end
        if (victim < 0) begin
          // oldest rank wins, lowest way on ties
          victim = 0;
          oldest = 0;
          for (int w = 0; w < nways; w++) begin
            if (int'(line_rank[base + w]) > oldest) begin
              oldest = int'(line_rank[base + w]);
              victim = w;
            end
          end
          r.evicted = 1'b1;
        end
        make_recent(base, victim, nways, r.evicted);
        line_valid[base + victim] = 1'b1;
        line_tag[base + victim]   = tag;
        r.way = WAY_OUT_W'(victim);
      end
      r.hit_count  = hits_total;
      r.miss_count = misses_total;
      expected_lookups.push_back(r);
      accesses++;
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      if (expected_lookups.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: expected none, actual %p", $time, got);
        return;
      end
      want = expected_lookups.pop_front();
      compare_field("hit",        COUNT_W'(want.hit),       COUNT_W'(got.hit));
      compare_field("set_index",  COUNT_W'(want.set_index), COUNT_W'(got.set_index));
      compare_field("way",        COUNT_W'(want.way),       COUNT_W'(got.way));
      compare_field("evicted",    COUNT_W'(want.evicted),   COUNT_W'(got.evicted));
      compare_field("hit_count",  want.hit_count,  got.hit_count);
      compare_field("miss_count", want.miss_count, got.miss_count);
      if (got.hit === 1'b1) hits_seen++;
      if (got.evicted === 1'b1) evictions_seen++;
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for set_associative_cache_tag_lru_core.
module tb_top;
  import satl_pkg::*;
  import satl_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 116;
  localparam int IDLE_PCT        = 28;
  localparam int WILD_ADDR_PCT   = 15;
  localparam int SETTLE_CYCLES   = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    steady = 1'b0;
  int                    cycle_count = 0;
  int                    settings_used = 1;

  satl_req_if req_ch();
  satl_rsp_if rsp_ch();

  lru_tag_scoreboard cache_sb = new();

  set_associative_cache_tag_lru_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check each accepted word, stall at random
  initial begin
    lookup_result_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.hit        = rsp_ch.hit;
        got.set_index  = rsp_ch.set_index;
        got.way        = rsp_ch.way;
        got.evicted    = rsp_ch.evicted;
        got.hit_count  = rsp_ch.hit_count;
        got.miss_count = rsp_ch.miss_count;
        cache_sb.check_result(got);
      end
      rsp_ch.ready <= !rst && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_lookup(logic [ADDR_W-1:0] addr);
    int gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    cache_sb.note_access(addr);
  endtask

  // block must be idle before any config write
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (cache_sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_port(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cache_sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] ob, logic [CFG_DATA_W-1:0] sbits,
                            logic [CFG_DATA_W-1:0] nways);
    drain();
    write_port(REG_OFFSET_BITS, ob);
    write_port(REG_SET_BITS, sbits);
    write_port(REG_WAYS_IN_USE, nways);
    write_port(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // mostly a few tags over a few sets so lines hit and get evicted; some wild addresses
  task automatic run_random(int count);
    int                ob;
    int                sbits;
    int                nways;
    int                shift;
    logic [ADDR_W-1:0] tag_base;
    logic [ADDR_W-1:0] set_base;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] set_sel;
    logic [ADDR_W-1:0] addr;
    ob       = cache_sb.eff_offset();
    sbits    = cache_sb.eff_set_bits();
    nways    = cache_sb.eff_ways();
    shift    = ob + sbits;
    tag_base = $urandom;
    set_base = $urandom_range(0, SETS - 1);
    repeat (count) begin
      if ($urandom_range(99) < WILD_ADDR_PCT) begin
        addr = $urandom;
      end else begin
        tag     = tag_base + $urandom_range(0, nways + 1);
        set_sel = (set_base + $urandom_range(0, 3)) & ((32'd1 << sbits) - 32'd1);
        addr    = (tag << shift) | (set_sel << ob) | ($urandom & ((32'd1 << ob) - 32'd1));
      end
      send_lookup(addr);
    end
  endtask

  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.address <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_OFFSET_BITS;
    cfg_data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset split: 4 offset bits, 3 set bits, 2 ways -> tag is addr >> 7
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_000F);
    send_lookup(32'h0000_0080);
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_0100);  // set 0 full: replaces LRU way 1
    send_lookup(32'h0000_0080);  // replaces way 0
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFF0);
    send_lookup(32'h0000_0070);
    send_lookup(32'h7FFF_FFFF);
    send_lookup(32'h8000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0170);
    send_lookup(32'h5555_5555);
    send_lookup(32'hAAAA_AAAA);
    send_lookup(32'h0000_0100);
    run_random(ITEMS_PER_PHASE);

    // lines stay valid across every change of split
    set_config(5'd0, 5'd0, 5'd8);     // fully associative, byte lines
    run_random(ITEMS_PER_PHASE);
    set_config(5'd16, 5'd8, 5'd8);
    run_random(ITEMS_PER_PHASE);
    set_config(5'd0, 5'd8, 5'd1);     // direct mapped
    steady <= 1'b1;
    run_random(ITEMS_PER_PHASE);
    drain();
    steady <= 1'b0;
    set_config(5'd31, 5'd15, 5'd15); // all clamped
    run_random(ITEMS_PER_PHASE);
    set_config(5'd17, 5'd9, 5'd0);
    run_random(ITEMS_PER_PHASE);
    set_config(5'd2, 5'd2, 5'd4);
    run_random(ITEMS_PER_PHASE);
    set_config(5'h14, 5'h13, 5'h14); // upper data bit dropped on the 4-bit registers
    run_random(ITEMS_PER_PHASE);
    set_config(5'd3, 5'd1, 5'd3);
    run_random(ITEMS_PER_PHASE);
    set_config(5'd8, 5'd4, 5'd5);
    run_random(ITEMS_PER_PHASE);
    repeat (3) begin
      set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      run_random(ITEMS_PER_PHASE);
    end
    set_config(5'd4, 5'd3, 5'd2);
    run_random(ITEMS_PER_PHASE);
    drain();

    $display("Ran %0d lookups under %0d cache settings: %0d hits, %0d evictions.",
             cache_sb.accesses, settings_used, cache_sb.hits_seen, cache_sb.evictions_seen);
    $display("Result mismatches: %0d", cache_sb.mismatches);
    if (cache_sb.mismatches == 0 && cache_sb.expected_lookups.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
